// File: design/ddmix_pkg.sv
// ddmix_pkg: shared types and constants of the drive command mixer
// payload structs for the command and wheel frame beats, register map, fixed widths
// depends on nothing
package ddmix_pkg;

    localparam int SPEED_W    = 16;
    localparam int HEAD_W     = 16;
    localparam int GAIN_W     = 13;
    localparam int STEER_W    = 12;
    localparam int SPIN_W     = 13;
    localparam int PWM_W      = 8;
    localparam int FRAME_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int MUL_B_W    = 14;
    localparam int SV_W       = SPEED_W + GAIN_W;
    localparam int SUM_W      = HEAD_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TAG  = 3'd7;

    localparam logic [GAIN_W-1:0]  RST_LEFT_GAIN  = 13'd4096;
    localparam logic [GAIN_W-1:0]  RST_RIGHT_GAIN = 13'd4096;
    localparam logic [STEER_W-1:0] RST_STEER_GAIN = 12'd410;
    localparam logic [GAIN_W-1:0]  RST_VEL_GAIN   = 13'd4096;
    localparam logic [SPIN_W-1:0]  RST_SPIN_LEVEL = 13'd410;
    localparam logic [PWM_W-1:0]   RST_PWM_MIN    = 8'd130;
    localparam logic [PWM_W-1:0]   RST_PWM_MAX    = 8'd255;
    localparam logic [FRAME_W-1:0] RST_FRAME_TAG  = 11'd0;

    typedef struct packed {
        logic [SPEED_W-1:0]       speed_val;
        logic signed [HEAD_W-1:0] head_rate;
        logic                     dir_cmd;
        logic                     stop_flag;
    } in_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_ident;
        logic [PWM_W-1:0]   right_duty;
        logic               right_dir;
        logic               right_stop;
        logic [PWM_W-1:0]   left_duty;
        logic               left_dir;
        logic               left_stop;
    } out_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  left_gain;
        logic [GAIN_W-1:0]  right_gain;
        logic [STEER_W-1:0] steer_gain;
        logic [GAIN_W-1:0]  vel_gain;
        logic [SPIN_W-1:0]  spin_level;
        logic [PWM_W-1:0]   pwm_min;
        logic [PWM_W-1:0]   pwm_max;
        logic [FRAME_W-1:0] frame_tag;
    } cfg_t;

endpackage

// File: design/ddmix_cfg.sv
// ddmix_cfg: configuration register file of the drive command mixer
// decodes write beats by register index, holds reset values
// depends on ddmix_pkg
module ddmix_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ddmix_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ddmix_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ddmix_pkg::cfg_t                    regs
);

    ddmix_pkg::cfg_t regs_reg;
    ddmix_pkg::cfg_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ddmix_pkg::REG_LEFT_GAIN:
                    regs_next.left_gain  = cfg_data[ddmix_pkg::GAIN_W-1:0];
                ddmix_pkg::REG_RIGHT_GAIN:
                    regs_next.right_gain = cfg_data[ddmix_pkg::GAIN_W-1:0];
                ddmix_pkg::REG_STEER_GAIN:
                    regs_next.steer_gain = cfg_data[ddmix_pkg::STEER_W-1:0];
                ddmix_pkg::REG_VEL_GAIN:
                    regs_next.vel_gain   = cfg_data[ddmix_pkg::GAIN_W-1:0];
                ddmix_pkg::REG_SPIN_LEVEL:
                    regs_next.spin_level = cfg_data[ddmix_pkg::SPIN_W-1:0];
                ddmix_pkg::REG_PWM_MIN:
                    regs_next.pwm_min    = cfg_data[ddmix_pkg::PWM_W-1:0];
                ddmix_pkg::REG_PWM_MAX:
                    regs_next.pwm_max    = cfg_data[ddmix_pkg::PWM_W-1:0];
                ddmix_pkg::REG_FRAME_TAG:
                    regs_next.frame_tag  = cfg_data[ddmix_pkg::FRAME_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.left_gain  <= ddmix_pkg::RST_LEFT_GAIN;
            regs_reg.right_gain <= ddmix_pkg::RST_RIGHT_GAIN;
            regs_reg.steer_gain <= ddmix_pkg::RST_STEER_GAIN;
            regs_reg.vel_gain   <= ddmix_pkg::RST_VEL_GAIN;
            regs_reg.spin_level <= ddmix_pkg::RST_SPIN_LEVEL;
            regs_reg.pwm_min    <= ddmix_pkg::RST_PWM_MIN;
            regs_reg.pwm_max    <= ddmix_pkg::RST_PWM_MAX;
            regs_reg.frame_tag  <= ddmix_pkg::RST_FRAME_TAG;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// File: design/ddmix_smul.sv
// ddmix_smul: bit-serial signed multiplier, one multiplier bit per cycle
// multiplier shifts out lsb first, partial product shifts right into a low register
// depends on nothing
module ddmix_smul #(
    parameter int A_W = 38,
    parameter int B_W = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [A_W-1:0]   a,
    input  logic signed [B_W-1:0]   b,
    output logic                    done,
    output logic signed [A_W+B_W-1:0] prod
);

    localparam int CW = $clog2(B_W);

    logic signed [A_W-1:0] a_reg, a_next;
    logic [B_W-1:0]        b_reg, b_next;
    logic signed [A_W-1:0] hi_reg, hi_next;
    logic [B_W-1:0]        lo_reg, lo_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic                  last;
    logic signed [A_W:0]   a_ext;
    logic signed [A_W:0]   addend;
    logic signed [A_W:0]   sum;

    assign last   = (cnt_reg == CW'(B_W - 1));
    assign a_ext  = (A_W + 1)'(a_reg);
    assign addend = b_reg[0] ? (last ? -a_ext : a_ext) : '0;
    assign sum    = (A_W + 1)'(hi_reg) + addend;

    assign done = done_reg;
    assign prod = $signed({hi_reg, lo_reg});

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // sign bit of the multiplier weighs negative
            hi_next  = sum[A_W:1];
            lo_next  = {sum[0], lo_reg[B_W-1:1]};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

endmodule

// File: design/diff_drive_motor_command_mixer_unit.sv
// diff_drive_motor_command_mixer_unit: top level of the drive command mixer
// sequencer, steering and clamp datapath, output register; uses ddmix_cfg and ddmix_smul
// depends on ddmix_pkg
//
//  channel  signals                                  beat
//  cmd in   in_valid  in_ready  in_data              speed, heading, direction, stop
//  frame    out_valid out_ready out_data             frame id, duty, dir, stop per wheel
//  config   cfg_valid cfg_ready cfg_index cfg_data   one register write
//
// one command at a time; all products go through one 14-step bit-serial multiplier
// moving command: six products from accept to frame valid
// turn or hold in place: four products; repeated command: accepted, no beat
// a finished frame waits in the output register while the next command is taken
// reset clears the last command and heading memory; config registers take reset values
module diff_drive_motor_command_mixer_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ddmix_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ddmix_pkg::out_t                     out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ddmix_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddmix_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = 3 * FRAC_BITS + 2;
    localparam int MB = ddmix_pkg::MUL_B_W;
    localparam int PW = AW + MB;
    localparam int HW = 17 - FRAC_BITS;
    localparam int SUMW = ddmix_pkg::SUM_W;
    localparam int SVW = ddmix_pkg::SV_W;
    localparam int PWMW = ddmix_pkg::PWM_W;

    localparam logic signed [PW-1:0] ONE2 = PW'(1) << (2 * FRAC_BITS);
    localparam logic signed [PW-1:0] ONE3 = PW'(1) << (3 * FRAC_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SV    = 3'd1;
    localparam logic [2:0] S_STEER = 3'd2;
    localparam logic [2:0] S_LG    = 3'd3;
    localparam logic [2:0] S_LP    = 3'd4;
    localparam logic [2:0] S_RG    = 3'd5;
    localparam logic [2:0] S_RP    = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    ddmix_pkg::cfg_t cfg;

    logic [2:0]                          state_reg, state_next;
    logic                                go_reg, go_next;
    logic [ddmix_pkg::SPEED_W-1:0]       prev_speed_reg, prev_speed_next;
    logic signed [ddmix_pkg::HEAD_W-1:0] prev_heading_reg, prev_heading_next;
    logic                                prev_dir_reg, prev_dir_next;
    logic                                prev_stop_reg, prev_stop_next;
    logic signed [HW-1:0]                hw_last_reg, hw_last_next;
    logic signed [SUMW-1:0]              sum_reg, sum_next;
    logic [SVW-1:0]                      sv_reg, sv_next;
    logic signed [AW-1:0]                x_l_reg, x_l_next;
    logic signed [AW-1:0]                x_r_reg, x_r_next;
    logic signed [AW-1:0]                v_reg, v_next;
    logic [PWMW-1:0]                     duty_l_reg, duty_l_next;
    logic [PWMW-1:0]                     duty_r_reg, duty_r_next;
    logic                                ldir_reg, ldir_next;
    logic                                rdir_reg, rdir_next;
    logic                                stop_reg, stop_next;
    logic                                out_valid_reg, out_valid_next;
    ddmix_pkg::out_t                     out_data_reg, out_data_next;

    logic                                same_cmd;
    logic signed [16:0]                  head17;
    logic signed [16:0]                  mag17;
    logic signed [16:0]                  quot17;
    logic signed [16:0]                  hw17;
    logic signed [SUMW-1:0]              sum_calc;
    logic signed [AW-1:0]                mul_a;
    logic signed [MB-1:0]                mul_b;
    logic                                mul_done;
    logic signed [PW-1:0]                mul_prod;
    logic signed [8:0]                   span;
    logic signed [PW-1:0]                sv_ext;
    logic signed [PW-1:0]                side_l;
    logic signed [PW-1:0]                side_r;
    logic signed [PW-1:0]                clamp_l;
    logic signed [PW-1:0]                clamp_r;
    logic signed [PW-1:0]                clamp_v;
    logic [PWMW-1:0]                     duty_calc;

    ddmix_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    ddmix_smul #(
        .A_W (AW),
        .B_W (MB)
    ) u_smul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // whole part of the heading, truncated toward zero
    assign head17 = 17'(in_data.head_rate);
    assign mag17  = in_data.head_rate[15] ? -head17 : head17;
    assign quot17 = mag17 >>> FRAC_BITS;
    assign hw17   = in_data.head_rate[15] ? -quot17 : quot17;

    // heading plus its change against the last whole part
    assign sum_calc = (SUMW'(in_data.head_rate) <<< 1)
                    - (SUMW'(hw_last_reg) <<< FRAC_BITS);

    assign same_cmd = (in_data.speed_val == prev_speed_reg)
                   && (in_data.head_rate == prev_heading_reg)
                   && (in_data.dir_cmd == prev_dir_reg)
                   && (in_data.stop_flag == prev_stop_reg);

    assign span = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});

    always_comb
    begin
        case (state_reg)
            S_SV:
            begin
                mul_a = $signed(AW'(prev_speed_reg));
                mul_b = $signed(MB'(cfg.vel_gain));
            end
            S_STEER:
            begin
                mul_a = AW'(sum_reg);
                mul_b = $signed(MB'(cfg.steer_gain));
            end
            S_LG:
            begin
                mul_a = x_l_reg;
                mul_b = $signed(MB'(cfg.left_gain));
            end
            S_RG:
            begin
                mul_a = x_r_reg;
                mul_b = $signed(MB'(cfg.right_gain));
            end
            S_LP, S_RP:
            begin
                mul_a = v_reg;
                mul_b = MB'(span);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // side drive clamped to [0, 1] in q.2f, wheel value clamped at 1 in q.3f
    assign sv_ext  = $signed(PW'(sv_reg));
    assign side_l  = sv_ext + mul_prod;
    assign side_r  = sv_ext - mul_prod;
    assign clamp_l = (side_l < 0) ? '0 : ((side_l > ONE2) ? ONE2 : side_l);
    assign clamp_r = (side_r < 0) ? '0 : ((side_r > ONE2) ? ONE2 : side_r);
    assign clamp_v = (mul_prod > ONE3) ? ONE3 : mul_prod;
    assign duty_calc = PWMW'(cfg.pwm_min + mul_prod[3*FRAC_BITS +: PWMW]);

    always_comb
    begin
        state_next        = state_reg;
        go_next           = 1'b0;
        prev_speed_next   = prev_speed_reg;
        prev_heading_next = prev_heading_reg;
        prev_dir_next     = prev_dir_reg;
        prev_stop_next    = prev_stop_reg;
        hw_last_next      = hw_last_reg;
        sum_next          = sum_reg;
        sv_next           = sv_reg;
        x_l_next          = x_l_reg;
        x_r_next          = x_r_reg;
        v_next            = v_reg;
        duty_l_next       = duty_l_reg;
        duty_r_next       = duty_r_reg;
        ldir_next         = ldir_reg;
        rdir_next         = rdir_reg;
        stop_next         = stop_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !same_cmd)
                begin
                    prev_speed_next   = in_data.speed_val;
                    prev_heading_next = in_data.head_rate;
                    prev_dir_next     = in_data.dir_cmd;
                    prev_stop_next    = in_data.stop_flag;
                    stop_next         = in_data.stop_flag;
                    go_next           = 1'b1;
                    if (in_data.speed_val == '0)
                    begin
                        if (in_data.head_rate != '0)
                        begin
                            // turning in place
                            x_l_next  = $signed(AW'(cfg.spin_level) << FRAC_BITS);
                            x_r_next  = $signed(AW'(cfg.spin_level) << FRAC_BITS);
                            ldir_next = in_data.head_rate[15];
                            rdir_next = !in_data.head_rate[15];
                        end
                        else
                        begin
                            x_l_next  = '0;
                            x_r_next  = '0;
                            ldir_next = in_data.dir_cmd;
                            rdir_next = in_data.dir_cmd;
                        end
                        state_next = S_LG;
                    end
                    else
                    begin
                        sum_next     = sum_calc;
                        hw_last_next = hw17[HW-1:0];
                        ldir_next    = in_data.dir_cmd;
                        rdir_next    = in_data.dir_cmd;
                        state_next   = S_SV;
                    end
                end
            end
            S_SV:
            begin
                if (mul_done)
                begin
                    sv_next    = mul_prod[SVW-1:0];
                    go_next    = 1'b1;
                    state_next = S_STEER;
                end
            end
            S_STEER:
            begin
                if (mul_done)
                begin
                    x_l_next   = clamp_l[AW-1:0];
                    x_r_next   = clamp_r[AW-1:0];
                    go_next    = 1'b1;
                    state_next = S_LG;
                end
            end
            S_LG:
            begin
                if (mul_done)
                begin
                    v_next     = clamp_v[AW-1:0];
                    go_next    = 1'b1;
                    state_next = S_LP;
                end
            end
            S_LP:
            begin
                if (mul_done)
                begin
                    duty_l_next = duty_calc;
                    go_next     = 1'b1;
                    state_next  = S_RG;
                end
            end
            S_RG:
            begin
                if (mul_done)
                begin
                    v_next     = clamp_v[AW-1:0];
                    go_next    = 1'b1;
                    state_next = S_RP;
                end
            end
            S_RP:
            begin
                if (mul_done)
                begin
                    duty_r_next = duty_calc;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.frame_ident = cfg.frame_tag;
                    out_data_next.right_duty  = duty_r_reg;
                    out_data_next.right_dir   = rdir_reg;
                    out_data_next.right_stop  = stop_reg;
                    out_data_next.left_duty   = duty_l_reg;
                    out_data_next.left_dir    = ldir_reg;
                    out_data_next.left_stop   = stop_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            go_reg           <= 1'b0;
            prev_speed_reg   <= '0;
            prev_heading_reg <= '0;
            prev_dir_reg     <= 1'b0;
            prev_stop_reg    <= 1'b0;
            hw_last_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            go_reg           <= go_next;
            prev_speed_reg   <= prev_speed_next;
            prev_heading_reg <= prev_heading_next;
            prev_dir_reg     <= prev_dir_next;
            prev_stop_reg    <= prev_stop_next;
            hw_last_reg      <= hw_last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        sv_reg       <= sv_next;
        x_l_reg      <= x_l_next;
        x_r_reg      <= x_r_next;
        v_reg        <= v_next;
        duty_l_reg   <= duty_l_next;
        duty_r_reg   <= duty_r_next;
        ldir_reg     <= ldir_next;
        rdir_reg     <= rdir_next;
        stop_reg     <= stop_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: tb/tb_diff_drive_motor_command_mixer_unit.sv
// tb_diff_drive_motor_command_mixer_unit: self-checking bench for the drive command mixer
// predicts every wheel frame from its own fixed point copy of the mixer and checks each beat
// depends on ddmix_pkg and diff_drive_motor_command_mixer_unit
module tb_diff_drive_motor_command_mixer_unit;

    import ddmix_pkg::*;

    localparam int     FRAC     = 12;
    localparam longint UNIT     = longint'(1) << FRAC;
    localparam longint UNIT2    = longint'(1) << (2 * FRAC);
    localparam longint UNIT3    = longint'(1) << (3 * FRAC);
    localparam int     TAIL     = 150;
    localparam int     MAX_GAP  = 11;
    localparam logic   DIR_FWD  = 1'b0;
    localparam logic   DIR_REV  = 1'b1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_t                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    cfg_t  mix_cfg;
    in_t   last_cmd;
    int    head_whole;
    out_t  pending_frames[$];
    int    bad_beats   = 0;
    bit    tx_idle_on  = 1'b1;
    bit    rx_idle_on  = 1'b1;
    int    rx_hold_req = 0;

    diff_drive_motor_command_mixer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic cfg_t reset_config();
        cfg_t c;
        c.left_gain  = RST_LEFT_GAIN;
        c.right_gain = RST_RIGHT_GAIN;
        c.steer_gain = RST_STEER_GAIN;
        c.vel_gain   = RST_VEL_GAIN;
        c.spin_level = RST_SPIN_LEVEL;
        c.pwm_min    = RST_PWM_MIN;
        c.pwm_max    = RST_PWM_MAX;
        c.frame_tag  = RST_FRAME_TAG;
        return c;
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.left_gain  = GAIN_W'($urandom_range(0, 8191));
        c.right_gain = GAIN_W'($urandom_range(0, 8191));
        c.steer_gain = STEER_W'($urandom_range(0, 4095));
        c.vel_gain   = GAIN_W'($urandom_range(0, 8191));
        c.spin_level = SPIN_W'($urandom_range(0, 4096));
        c.pwm_min    = PWM_W'($urandom_range(0, 255));
        c.pwm_max    = PWM_W'($urandom_range(0, 255));
        c.frame_tag  = FRAME_W'($urandom_range(0, 2047));
        return c;
    endfunction

    function automatic in_t drive_cmd(input logic [15:0] spd, input logic [15:0] head,
                                      input logic dir, input logic stp);
        in_t c;
        c.speed_val = spd;
        c.head_rate = head;
        c.dir_cmd   = dir;
        c.stop_flag = stp;
        return c;
    endfunction

    // side drive in Q24 to duty code, gain applied and clamped at full drive
    function automatic logic [PWM_W-1:0] side_duty(input longint drive, input longint gain);
        longint v;
        longint total;
        v = drive * gain;
        if (v > UNIT3)
            v = UNIT3;
        total = longint'(mix_cfg.pwm_min) * UNIT3
              + v * (longint'(mix_cfg.pwm_max) - longint'(mix_cfg.pwm_min));
        if (total < 0)
            total = 0;
        return total[3*FRAC +: PWM_W];
    endfunction

    function automatic bit predict_wheel_frame(input in_t c, output out_t f);
        longint head;
        longint spd;
        longint steer;
        longint scaled;
        longint lx;
        longint rx;
        logic   ldir;
        logic   rdir;
        f = '0;
        if (c == last_cmd)
            return 1'b0;
        last_cmd = c;
        head = longint'($signed(c.head_rate));
        spd  = longint'(c.speed_val);
        lx   = 0;
        rx   = 0;
        ldir = c.dir_cmd;
        rdir = c.dir_cmd;
        if (spd == 0 && head != 0)
        begin
            ldir = (head > 0) ? DIR_FWD : DIR_REV;
            rdir = (head > 0) ? DIR_REV : DIR_FWD;
            lx   = longint'(mix_cfg.spin_level) * UNIT;
            rx   = lx;
        end
        if (spd > 0)
        begin
            steer      = (2 * head - longint'(head_whole) * UNIT) * longint'(mix_cfg.steer_gain);
            scaled     = spd * longint'(mix_cfg.vel_gain);
            head_whole = int'(head / UNIT);
            lx = scaled + steer;
            rx = scaled - steer;
            lx = (lx < 0) ? 0 : ((lx > UNIT2) ? UNIT2 : lx);
            rx = (rx < 0) ? 0 : ((rx > UNIT2) ? UNIT2 : rx);
        end
        f.frame_ident = mix_cfg.frame_tag;
        f.right_duty  = side_duty(rx, longint'(mix_cfg.right_gain));
        f.right_dir   = rdir;
        f.right_stop  = c.stop_flag;
        f.left_duty   = side_duty(lx, longint'(mix_cfg.left_gain));
        f.left_dir    = ldir;
        f.left_stop   = c.stop_flag;
        return 1'b1;
    endfunction

    function automatic in_t random_command();
        in_t c;
        int  kind;
        kind = $urandom_range(0, 99);
        c.speed_val = SPEED_W'($urandom_range(0, 65535));
        c.head_rate = HEAD_W'($urandom_range(0, 65535));
        c.dir_cmd   = 1'($urandom_range(0, 1));
        c.stop_flag = 1'($urandom_range(0, 1));
        if (kind < 8)
        begin
            c = last_cmd;
        end
        else if (kind < 20)
        begin
            c.speed_val = '0;
            if (c.head_rate == '0)
                c.head_rate = 16'sd1;
        end
        else if (kind < 25)
        begin
            c.speed_val = '0;
            c.head_rate = '0;
        end
        else if (kind < 75)
        begin
            c.speed_val = SPEED_W'($urandom_range(1, 8191));
            c.head_rate = HEAD_W'($urandom_range(0, 16383)) - 16'd8192;
        end
        return c;
    endfunction

    task automatic send_command(input in_t c, output bit framed);
        int   gap;
        out_t f;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        do @(posedge clk); while (!(in_valid && in_ready));
        framed = predict_wheel_frame(c, f);
        if (framed)
            pending_frames.insert(pending_frames.size(), f);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        for (int k = 0; k < 8; k++)
        begin
            idx = k[CFG_IDX_W-1:0];
            case (idx)
                REG_LEFT_GAIN:  val = c.left_gain;
                REG_RIGHT_GAIN: val = c.right_gain;
                REG_STEER_GAIN: val = CFG_DATA_W'(c.steer_gain);
                REG_VEL_GAIN:   val = c.vel_gain;
                REG_SPIN_LEVEL: val = c.spin_level;
                REG_PWM_MIN:    val = CFG_DATA_W'(c.pwm_min);
                REG_PWM_MAX:    val = CFG_DATA_W'(c.pwm_max);
                default:        val = CFG_DATA_W'(c.frame_tag);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
        mix_cfg = c;
    endtask

    task automatic run_random(input int frames);
        int got;
        bit framed;
        got = 0;
        while (got < frames)
        begin
            send_command(random_command(), framed);
            if (framed)
                got++;
        end
    endtask

    task automatic test_directed();
        bit framed;
        in_t cmds[$];
        cmds = '{
            drive_cmd(0, 0, DIR_FWD, 1'b0),
            drive_cmd(0, 0, DIR_REV, 1'b0),
            drive_cmd(0, 0, DIR_REV, 1'b0),
            drive_cmd(0, 4096, DIR_FWD, 1'b0),
            drive_cmd(0, -4096, DIR_REV, 1'b1),
            drive_cmd(0, 1, DIR_FWD, 1'b0),
            drive_cmd(0, -1, DIR_FWD, 1'b0),
            drive_cmd(0, 32767, DIR_REV, 1'b0),
            drive_cmd(0, -32768, DIR_FWD, 1'b1),
            drive_cmd(4096, 0, DIR_FWD, 1'b0),
            drive_cmd(4096, 12288, DIR_FWD, 1'b0),
            drive_cmd(4096, 12289, DIR_FWD, 1'b0),
            drive_cmd(4096, -12289, DIR_REV, 1'b0),
            drive_cmd(4096, -12289, DIR_REV, 1'b0),
            drive_cmd(65535, 32767, DIR_FWD, 1'b1),
            drive_cmd(65535, -32768, DIR_REV, 1'b0),
            drive_cmd(1, 0, DIR_FWD, 1'b0),
            drive_cmd(1, -1, DIR_FWD, 1'b1),
            drive_cmd(8192, 8191, DIR_REV, 1'b1),
            drive_cmd(65535, 0, DIR_FWD, 1'b0),
            drive_cmd(0, 0, DIR_FWD, 1'b1),
            drive_cmd(300, -300, DIR_FWD, 1'b0),
            drive_cmd(0, 4095, DIR_FWD, 1'b0),
            drive_cmd(32768, -4096, DIR_REV, 1'b1)
        };
        foreach (cmds[i])
            send_command(cmds[i], framed);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        cfg_t sets[$];
        cfg_t c;
        c = '0;
        sets.insert(sets.size(), c);
        c = '{left_gain: 8191, right_gain: 8191, steer_gain: 4095, vel_gain: 8191,
              spin_level: 4096, pwm_min: 0, pwm_max: 255, frame_tag: 2047};
        sets.insert(sets.size(), c);
        c = random_config();
        c.pwm_min = 255;
        c.pwm_max = 0;
        sets.insert(sets.size(), c);
        c = random_config();
        c.vel_gain   = 8191;
        c.steer_gain = 0;
        c.left_gain  = 0;
        c.right_gain = 8191;
        sets.insert(sets.size(), c);
        c = '{left_gain: 8191, right_gain: 8191, steer_gain: 4095, vel_gain: 8191,
              spin_level: 4096, pwm_min: 200, pwm_max: 10, frame_tag: 1365};
        sets.insert(sets.size(), c);
        c = random_config();
        c.pwm_min = 77;
        c.pwm_max = 77;
        sets.insert(sets.size(), c);
        foreach (sets[i])
        begin
            load_config(sets[i]);
            tx_idle_on = (i % 2 == 0);
            rx_idle_on = (i % 3 != 0);
            run_random(25);
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        bit framed;
        load_config(reset_config());
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 600;
        repeat (12) send_command(random_command(), framed);
        // sender holds off until every frame is back, then carries on
        wait_idle();
        repeat (6) send_command(random_command(), framed);
        wait_idle();
    endtask

    task automatic test_random();
        for (int p = 0; p < 10; p++)
        begin
            load_config((p == 0) ? reset_config() : random_config());
            tx_idle_on = (p % 4 != 1);
            rx_idle_on = (p % 4 != 2);
            run_random(100);
            wait_idle();
        end
    endtask

    initial
    begin : frame_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req != 0)
            begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            else
            begin
                gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready) && rx_hold_req == 0);
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected frame beat: got %h", out_data);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (out_data.frame_ident !== want.frame_ident ||
                    out_data.right_duty  !== want.right_duty  ||
                    out_data.right_dir   !== want.right_dir   ||
                    out_data.right_stop  !== want.right_stop  ||
                    out_data.left_duty   !== want.left_duty   ||
                    out_data.left_dir    !== want.left_dir    ||
                    out_data.left_stop   !== want.left_stop)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("frame mismatch: expected %h got %h", want, out_data);
                end
            end
        end
    end

    initial
    begin
        mix_cfg    = reset_config();
        last_cmd   = '0;
        head_whole = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        wait_idle();
        if (bad_beats == 0 && pending_frames.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
